// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared types, constants and the class function of the sorted priority queue
// used by spq_cell and sorted_priority_queue; depends on nothing else
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TAG_W   = 32;
   localparam int AGE_W   = 7;
   localparam int CLS_W   = 3;
   localparam int STAT_W  = 3;
   localparam int OCC_W   = 5;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_AGE  = 3'd4;

   // class codes, zero means no class
   localparam logic [CLS_W-1:0] CLS_NONE     = 3'd0;
   localparam logic [CLS_W-1:0] CLS_ELDER    = 3'd1;
   localparam logic [CLS_W-1:0] CLS_COMORBID = 3'd2;
   localparam logic [CLS_W-1:0] CLS_MIDDLE   = 3'd3;
   localparam logic [CLS_W-1:0] CLS_ADULT    = 3'd4;

   localparam logic [AGE_W-1:0] AGE_ELDER  = 7'd65;
   localparam logic [AGE_W-1:0] AGE_MIDDLE = 7'd45;
   localparam logic [AGE_W-1:0] AGE_ADULT  = 7'd18;

   typedef struct packed {
      logic             req_type;
      logic [TAG_W-1:0] patient_tag;
      logic [AGE_W-1:0] age_years;
      logic             comorbid;
   } spq_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  out_tag;
      logic [AGE_W-1:0]  out_age;
      logic              out_comorbid;
      logic [CLS_W-1:0]  out_class;
      logic [OCC_W-1:0]  occupancy;
   } spq_rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
      logic             cm;
      logic [CLS_W-1:0] cls;
   } spq_slot_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [CLS_W-1:0] cls;
   } spq_cell_ctl_type;

   function automatic logic [CLS_W-1:0] class_of(input logic [AGE_W-1:0] age,
                                                 input logic cm);
      logic [CLS_W-1:0] c;
      if (age > AGE_ELDER)       c = CLS_ELDER;
      else if (cm)               c = CLS_COMORBID;
      else if (age > AGE_MIDDLE) c = CLS_MIDDLE;
      else if (age > AGE_ADULT)  c = CLS_ADULT;
      else                       c = CLS_NONE;
      return c;
   endfunction

endpackage

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted queue, keeps, loads the new entry or shifts
// from a neighbor; depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
   input  logic                      clock,
   input  spq_pkg::spq_cell_ctl_type ctl,
   input  spq_pkg::spq_slot_type     new_slot,
   input  logic                      occupied,
   input  logic                      left_le,
   input  spq_pkg::spq_slot_type     left_slot,
   input  spq_pkg::spq_slot_type     right_slot,
   output spq_pkg::spq_slot_type     slot,
   output logic                      le
);

   spq_pkg::spq_slot_type slot_ff, slot_in;

   // entries of equal or better class stay ahead of the new one
   assign le = occupied && (slot_ff.cls <= ctl.cls);

   always_comb begin
      slot_in = slot_ff;
      if (ctl.ins) begin
         if (le)           slot_in = slot_ff;
         else if (left_le) slot_in = new_slot;
         else              slot_in = left_slot;
      end else if (ctl.rem) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded priority queue kept sorted in a row of cells
// depends on spq_pkg and spq_cell
//
//  channel | ports                       | direction | beat
//  req     | req_valid req_stall req_data | in        | insert or remove request
//  rsp     | rsp_valid rsp_stall rsp_data | out       | one result per request
//
// one request per cycle while req_stall is low; its result appears in the output register the next cycle
// all cells compare against the new class and shift in the same cycle
// reset clears the entry count and the output valid; slot contents are not cleared
// a stalled result holds req_stall high until the result is taken
`timescale 1ns / 1ps

module sorted_priority_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spq_pkg::spq_rsp_type rsp_data
);

   localparam int N = spq_pkg::DEPTH;

   logic [spq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_pkg::spq_rsp_type      rsp_data_ff, rsp_data_in;

   logic                      req_accept;
   logic                      is_insert;
   logic [spq_pkg::CLS_W-1:0] new_cls;
   logic                      full;
   logic                      empty;
   logic                      do_ins;
   logic                      do_rem;
   spq_pkg::spq_cell_ctl_type ctl;
   spq_pkg::spq_slot_type     new_slot;
   spq_pkg::spq_slot_type     slots [N];
   logic [N-1:0]              le;
   logic [N-1:0]              occ;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_insert = (req_data.req_type == spq_pkg::REQ_INSERT);
   assign new_cls   = spq_pkg::class_of(req_data.age_years, req_data.comorbid);
   assign full      = (count_ff >= spq_pkg::CNT_W'(N));
   assign empty     = (count_ff == '0);
   assign do_ins    = req_accept && is_insert && (new_cls != spq_pkg::CLS_NONE) && !full;
   assign do_rem    = req_accept && !is_insert && !empty;

   assign ctl.ins = do_ins;
   assign ctl.rem = do_rem;
   assign ctl.cls = new_cls;

   assign new_slot.tag = req_data.patient_tag;
   assign new_slot.age = req_data.age_years;
   assign new_slot.cm  = req_data.comorbid;
   assign new_slot.cls = new_cls;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occ[i] = (count_ff > spq_pkg::CNT_W'(i));
      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_slot   (new_slot),
         .occupied   (occ[i]),
         .left_le    ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
         .left_slot  (slots[(i == 0) ? 0 : i - 1]),
         .right_slot (slots[(i == N - 1) ? i : i + 1]),
         .slot       (slots[i]),
         .le         (le[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins)      count_in = count_ff + spq_pkg::CNT_W'(1);
      else if (do_rem) count_in = count_ff - spq_pkg::CNT_W'(1);
   end

   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.occupancy    = spq_pkg::OCC_W'(count_in);
      if (is_insert) begin
         if (new_cls == spq_pkg::CLS_NONE) begin
            rsp_data_in.status = spq_pkg::ST_BAD_AGE;
         end else if (full) begin
            rsp_data_in.status = spq_pkg::ST_FULL;
         end else begin
            rsp_data_in.status    = spq_pkg::ST_INSERTED;
            rsp_data_in.out_class = new_cls;
         end
      end else begin
         if (empty) begin
            rsp_data_in.status = spq_pkg::ST_EMPTY;
         end else begin
            rsp_data_in.status       = spq_pkg::ST_REMOVED;
            rsp_data_in.out_tag      = slots[0].tag;
            rsp_data_in.out_age      = slots[0].age;
            rsp_data_in.out_comorbid = slots[0].cm;
            rsp_data_in.out_class    = slots[0].cls;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)                    rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_W'(N))
      else $error("entry count above depth");

   // a successful insert grows the queue by one
   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> (count_ff == $past(count_ff) + spq_pkg::CNT_W'(1)))
      else $error("insert did not grow the queue");

   // a remove result always carries a real class
   a_rem_class: assert property (@(posedge clock) disable iff (reset)
      do_rem |=> (rsp_data_ff.out_class != spq_pkg::CLS_NONE))
      else $error("removed entry without class");

   // the head is never worse than the second entry
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff > spq_pkg::CNT_W'(1)) |-> (slots[0].cls <= slots[1].cls))
      else $error("queue head out of order");

   // an accepted request always yields a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("request lost its result");

endmodule
